// ===== rtl/core/cpsm_pkg.sv =====
package cpsm_pkg;

   // Channel map and field widths
   localparam int NUM_CHANNELS_DEFAULT = 5;
   localparam logic [2:0] ENGINE_CHANNEL = 3'd4;
   localparam int DATA_W = 32;
   localparam int HALF_W = 16;

   // Input item kinds and timers
   localparam logic KIND_OVERFLOW = 1'b0;
   localparam logic KIND_CAPTURE  = 1'b1;
   localparam logic TIMER_WHEEL   = 1'b0;
   localparam logic TIMER_ENGINE  = 1'b1;

   // Register file layout: register i at byte address 4*i
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_COUNTER_PERIOD  = 2'd0;
   localparam logic [1:0] REG_WHEEL_NUMERATOR = 2'd1;
   localparam logic [1:0] REG_ENGINE_NUMERATOR = 2'd2;

   // Register reset values
   localparam logic [15:0] COUNTER_PERIOD_RESET   = 16'd6400;
   localparam logic [31:0] WHEEL_NUMERATOR_RESET  = 32'd261274;
   localparam logic [31:0] ENGINE_NUMERATOR_RESET = 32'd92160000;

   typedef struct packed {
      logic        kind;
      logic        timer_id;
      logic [2:0]  channel;
      logic [15:0] capture_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  out_channel;
      logic [31:0] elapsed_ticks;
      logic [31:0] speed;
      logic        zero_period;
   } rsp_type;

endpackage

// ===== rtl/core/cpsm_divider.sv =====
module cpsm_divider
   import cpsm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] div_ff, div_in;

   logic [DATA_W:0]   shifted;
   logic [DATA_W+1:0] diff;
   logic              fits;

   // One restoring step: shift in the next dividend bit, try the subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      diff    = {1'b0, shifted} - {2'b00, div_ff};
      fits    = ~diff[DATA_W+1];
   end

   // Sequence the quotient bits, most significant first
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
         quo_in   = {quo_ff[DATA_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/capture_period_speed_meter_top.sv =====
// Input-capture speed meter for up to NUM_CHANNELS channels: channel 4 runs on the
// engine timer, the others on the wheel timer. An overflow tick bumps the saturating
// overflow count of every channel on that timer. A capture on a channel at or above
// NUM_CHANNELS is dropped. For a valid capture, the overflow count times
// counter_period is formed by a bit-serial shift-and-add multiplier, one multiplier
// bit per cycle up to the highest set bit of the 16-bit overflow count, and the speed
// by a radix-2 restoring divider, one quotient bit per cycle. A zero elapsed count
// skips the divider and reports all-ones speed with zero_period set. One capture is in
// flight at a time; the result sits in an output register, so the next item is taken
// while the previous result still waits on rsp_stall.
module capture_period_speed_meter_top
   import cpsm_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0]     csr_pwdata,
   output logic [DATA_W-1:0]     csr_prdata,
   output logic                  csr_pready
);

   localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [15:0]        period_ff, period_in;
   logic [DATA_W-1:0]  wheel_num_ff, wheel_num_in;
   logic [DATA_W-1:0]  engine_num_ff, engine_num_in;
   logic [HALF_W-1:0]  last_ff [NUM_CHANNELS];
   logic [HALF_W-1:0]  last_in [NUM_CHANNELS];
   logic [HALF_W-1:0]  ovf_ff [NUM_CHANNELS];
   logic [HALF_W-1:0]  ovf_in [NUM_CHANNELS];

   logic [DATA_W-1:0]  acc_ff, acc_in;
   logic [DATA_W-1:0]  mcand_ff, mcand_in;
   logic [HALF_W-1:0]  mplier_ff, mplier_in;
   logic [DATA_W-1:0]  num_ff, num_in;
   logic [2:0]         chan_ff, chan_in;
   logic [DATA_W-1:0]  speed_ff, speed_in;
   logic               zero_ff, zero_in;

   logic               req_take;
   logic               rsp_take;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic               cap_ok;
   logic [IW-1:0]      cap_idx;
   logic               div_start;
   logic               div_done;
   logic [DATA_W-1:0]  div_quotient;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign rsp_take  = rsp_valid_ff & ~rsp_stall;
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index = csr_paddr[3:2];
   assign cap_ok    = int'(req_data.channel) < NUM_CHANNELS;
   assign cap_idx   = IW'(req_data.channel);
   assign div_start = (state_ff == S_MUL) && (mplier_ff == '0) && (acc_ff != '0);

   // Read back the registers
   always_comb begin
      case (csr_index)
         REG_COUNTER_PERIOD:   csr_prdata = {16'b0, period_ff};
         REG_WHEEL_NUMERATOR:  csr_prdata = wheel_num_ff;
         REG_ENGINE_NUMERATOR: csr_prdata = engine_num_ff;
         default:              csr_prdata = '0;
      endcase
   end

   // Next-state logic for the sequencer, registers, channel counts and serial multiplier
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      period_in     = period_ff;
      wheel_num_in  = wheel_num_ff;
      engine_num_in = engine_num_ff;
      last_in       = last_ff;
      ovf_in        = ovf_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      num_in        = num_ff;
      chan_in       = chan_ff;
      speed_in      = speed_ff;
      zero_in       = zero_ff;

      // Drop the result once its transfer completes
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes
      if (csr_write) begin
         case (csr_index)
            REG_COUNTER_PERIOD:   period_in     = csr_pwdata[15:0];
            REG_WHEEL_NUMERATOR:  wheel_num_in  = csr_pwdata;
            REG_ENGINE_NUMERATOR: engine_num_in = csr_pwdata;
            default:              period_in     = period_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_data.kind == KIND_OVERFLOW) begin
                  // Bump every channel on the ticking timer, saturating
                  for (int i = 0; i < NUM_CHANNELS; i++) begin
                     if (((i == int'(ENGINE_CHANNEL)) ? TIMER_ENGINE : TIMER_WHEEL)
                         == req_data.timer_id && ovf_ff[i] != '1) begin
                        ovf_in[i] = ovf_ff[i] + 1'b1;
                     end
                  end
               end else if (cap_ok) begin
                  // Latch operands, store the capture and clear the count
                  acc_in    = {16'b0, req_data.capture_value} - {16'b0, last_ff[cap_idx]};
                  mplier_in = ovf_ff[cap_idx];
                  mcand_in  = {16'b0, period_ff};
                  num_in    = (req_data.channel == ENGINE_CHANNEL) ? engine_num_ff
                                                                   : wheel_num_ff;
                  chan_in   = req_data.channel;
                  last_in[cap_idx] = req_data.capture_value;
                  ovf_in[cap_idx]  = '0;
                  state_in  = S_MUL;
               end
            end
         end
         S_MUL: begin
            if (mplier_ff == '0) begin
               if (acc_ff == '0) begin
                  speed_in = '1;
                  zero_in  = 1'b1;
                  state_in = S_DONE;
               end else begin
                  zero_in  = 1'b0;
                  state_in = S_DIV;
               end
            end else begin
               // Add one shifted multiplicand per multiplier bit
               if (mplier_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               mcand_in  = {mcand_ff[DATA_W-2:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[HALF_W-1:1]};
            end
         end
         S_DIV: begin
            if (div_done) begin
               speed_in = div_quotient;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.out_channel   = chan_ff;
               rsp_data_in.elapsed_ticks = acc_ff;
               rsp_data_in.speed         = speed_ff;
               rsp_data_in.zero_period   = zero_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         period_ff     <= COUNTER_PERIOD_RESET;
         wheel_num_ff  <= WHEEL_NUMERATOR_RESET;
         engine_num_ff <= ENGINE_NUMERATOR_RESET;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            last_ff[i] <= '0;
            ovf_ff[i]  <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         period_ff     <= period_in;
         wheel_num_ff  <= wheel_num_in;
         engine_num_ff <= engine_num_in;
         last_ff       <= last_in;
         ovf_ff        <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      num_ff      <= num_in;
      chan_ff     <= chan_in;
      speed_ff    <= speed_in;
      zero_ff     <= zero_in;
   end

   // Serial divider for numerator over elapsed ticks
   cpsm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (acc_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sim/capture_period_speed_meter_top_tb.sv =====
`timescale 1ns / 100ps

module capture_period_speed_meter_top_tb;
   import cpsm_pkg::*;

   localparam int NCH = NUM_CHANNELS_DEFAULT;
   localparam int CLOCK_HALF = 5;
   localparam int RESET_CYCLES = 5;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 64;
   localparam int RANDOM_ITEMS = 480;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int OVERFLOW_RUN_TICKS = 40;
   localparam logic [1:0] REG_UNMAPPED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0]     csr_pwdata;
   logic [DATA_W-1:0]     csr_prdata;
   logic                  csr_pready;

   // Predictor state, kept in step with every observed transfer
   logic [15:0] mdl_period;
   logic [31:0] mdl_wheel_num;
   logic [31:0] mdl_engine_num;
   logic [15:0] mdl_last [NCH];
   logic [15:0] mdl_ovf [NCH];
   rsp_type     expected_readings [$];

   // Stimulus-side copy of the last capture per channel, used to aim at zero periods
   logic [15:0] gen_last [NCH];

   int send_idle_pct;
   int recv_stall_pct;
   int holdoff_left;
   int quiet_cycles;
   int mismatch_count;
   int readings_checked;
   int zero_readings;
   int overflow_ticks;
   int settings_count;

   capture_period_speed_meter_top #(
      .NUM_CHANNELS(NCH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial clock = 1'b0;
   always #(CLOCK_HALF) clock = ~clock;

   function automatic logic [CSR_ADDR_W-1:0] reg_addr(logic [1:0] idx);
      return {idx, 2'b00};
   endfunction

   function automatic logic timer_of(logic [2:0] ch);
      return (ch == ENGINE_CHANNEL) ? TIMER_ENGINE : TIMER_WHEEL;
   endfunction

   function automatic req_type make_item(logic kind, logic tmr, logic [2:0] ch,
                                         logic [15:0] cap);
      req_type item;
      item.kind = kind;
      item.timer_id = tmr;
      item.channel = ch;
      item.capture_value = cap;
      return item;
   endfunction

   function automatic logic [31:0] register_value(logic [1:0] idx);
      case (idx)
         REG_COUNTER_PERIOD: begin
            return {16'h0000, mdl_period};
         end
         REG_WHEEL_NUMERATOR: begin
            return mdl_wheel_num;
         end
         default: begin
            return mdl_engine_num;
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Advance the model by one accepted input transfer
   task automatic apply_transfer(req_type item);
      rsp_type reading;
      logic [31:0] numer;
      if (item.kind == KIND_OVERFLOW) begin
         overflow_ticks++;
         for (int i = 0; i < NCH; i++) begin
            if (timer_of(3'(i)) == item.timer_id && mdl_ovf[i] != 16'hFFFF) begin
               mdl_ovf[i] = mdl_ovf[i] + 16'd1;
            end
         end
      end else if (item.channel < NCH) begin
         reading.out_channel = item.channel;
         reading.elapsed_ticks = 32'(item.capture_value)
                                 + 32'(mdl_ovf[item.channel]) * 32'(mdl_period)
                                 - 32'(mdl_last[item.channel]);
         mdl_last[item.channel] = item.capture_value;
         mdl_ovf[item.channel] = 16'h0000;
         numer = (item.channel == ENGINE_CHANNEL) ? mdl_engine_num : mdl_wheel_num;
         if (reading.elapsed_ticks == 32'd0) begin
            reading.speed = 32'hFFFF_FFFF;
            reading.zero_period = 1'b1;
         end else begin
            reading.speed = numer / reading.elapsed_ticks;
            reading.zero_period = 1'b0;
         end
         expected_readings.push_back(reading);
      end
   endtask

   // Monitor: check results, then track register and input transfers
   always @(posedge clock) begin
      if (reset) begin
         mdl_period = COUNTER_PERIOD_RESET;
         mdl_wheel_num = WHEEL_NUMERATOR_RESET;
         mdl_engine_num = ENGINE_NUMERATOR_RESET;
         for (int i = 0; i < NCH; i++) begin
            mdl_last[i] = 16'h0000;
            mdl_ovf[i] = 16'h0000;
         end
         expected_readings.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               report_mismatch("reading with nothing pending, channel",
                               32'(rsp_data.out_channel), 32'd0);
            end else begin
               rsp_type want;
               want = expected_readings.pop_front();
               readings_checked++;
               if (want.zero_period) zero_readings++;
               if (rsp_data.out_channel !== want.out_channel)
                  report_mismatch("out_channel", 32'(rsp_data.out_channel),
                                  32'(want.out_channel));
               if (rsp_data.elapsed_ticks !== want.elapsed_ticks)
                  report_mismatch("elapsed_ticks", rsp_data.elapsed_ticks,
                                  want.elapsed_ticks);
               if (rsp_data.speed !== want.speed)
                  report_mismatch("speed", rsp_data.speed, want.speed);
               if (rsp_data.zero_period !== want.zero_period)
                  report_mismatch("zero_period", 32'(rsp_data.zero_period),
                                  32'(want.zero_period));
            end
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[3:2])
                  REG_COUNTER_PERIOD: begin
                     mdl_period = csr_pwdata[15:0];
                  end
                  REG_WHEEL_NUMERATOR: begin
                     mdl_wheel_num = csr_pwdata;
                  end
                  REG_ENGINE_NUMERATOR: begin
                     mdl_engine_num = csr_pwdata;
                  end
                  default: begin
                  end
               endcase
            end else if (csr_paddr[3:2] != REG_UNMAPPED) begin
               if (csr_prdata !== register_value(csr_paddr[3:2]))
                  report_mismatch("register read", csr_prdata,
                                  register_value(csr_paddr[3:2]));
            end
         end
         if (req_valid && !req_stall) apply_transfer(req_data);
      end
   end

   // Watchdog: end the run when nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: random stall, or hold off for a counted stretch
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Offer one item, with random idle cycles ahead of it; return at the next falling edge
   task automatic send_item(req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic capture(logic [2:0] ch, logic [15:0] cap);
      send_item(make_item(KIND_CAPTURE, logic'($urandom_range(1)), ch, cap));
      if (ch < NCH) gen_last[ch] = cap;
   endtask

   task automatic overflow_tick(logic tmr);
      send_item(make_item(KIND_OVERFLOW, tmr, 3'($urandom_range(7)), 16'($urandom)));
   endtask

   // Drop valid, drain pending readings, then let in-flight work finish
   task automatic settle_block;
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_access(logic wr, logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_settings(logic [15:0] period, logic [31:0] wheel,
                                 logic [31:0] engine);
      csr_access(1'b1, reg_addr(REG_COUNTER_PERIOD), {16'h0000, period});
      csr_access(1'b1, reg_addr(REG_WHEEL_NUMERATOR), wheel);
      csr_access(1'b1, reg_addr(REG_ENGINE_NUMERATOR), engine);
      csr_access(1'b0, reg_addr(REG_COUNTER_PERIOD), 32'd0);
      csr_access(1'b0, reg_addr(REG_WHEEL_NUMERATOR), 32'd0);
      csr_access(1'b0, reg_addr(REG_ENGINE_NUMERATOR), 32'd0);
      settings_count++;
   endtask

   task automatic test_reset_values;
      csr_access(1'b0, reg_addr(REG_COUNTER_PERIOD), 32'd0);
      csr_access(1'b0, reg_addr(REG_WHEEL_NUMERATOR), 32'd0);
      csr_access(1'b0, reg_addr(REG_ENGINE_NUMERATOR), 32'd0);
      settings_count++;
   endtask

   // Zero period, full range, wrap below zero, overflows on both timers
   task automatic test_basic_captures;
      capture(3'd0, 16'h0000);
      capture(3'd0, 16'hFFFF);
      capture(3'd0, 16'h0000);
      overflow_tick(TIMER_WHEEL);
      overflow_tick(TIMER_WHEEL);
      capture(3'd1, 16'd100);
      overflow_tick(TIMER_ENGINE);
      capture(3'd4, 16'hFFFF);
      capture(3'd4, 16'hFFFF);
      capture(3'd2, 16'h5555);
      capture(3'd3, 16'hAAAA);
      overflow_tick(TIMER_WHEEL);
      capture(3'd4, 16'h0001);
      capture(3'd1, 16'h8000);
      settle_block();
   endtask

   // Captures on unused channels must leave the channel state alone
   task automatic test_ignored_channels;
      capture(3'd5, 16'h1234);
      capture(3'd6, 16'hFFFF);
      capture(3'd7, 16'h0F0F);
      overflow_tick(TIMER_WHEEL);
      capture(3'd7, 16'h0000);
      capture(3'd0, 16'h0100);
      capture(3'd2, 16'h0000);
      settle_block();
   endtask

   // Smallest then largest settings, with unmapped writes that must do nothing
   task automatic test_register_extremes;
      write_settings(16'd1, 32'd1, 32'd1);
      capture(3'd0, 16'h8000);
      overflow_tick(TIMER_WHEEL);
      capture(3'd0, 16'h7FFF);
      capture(3'd4, 16'h8000);
      overflow_tick(TIMER_ENGINE);
      capture(3'd4, 16'h7FFF);
      capture(3'd3, 16'h0001);
      settle_block();
      csr_access(1'b1, {REG_UNMAPPED, 2'b00}, 32'hDEAD_BEEF);
      write_settings(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      capture(3'd1, 16'h0001);
      overflow_tick(TIMER_WHEEL);
      capture(3'd2, 16'hFFFF);
      overflow_tick(TIMER_ENGINE);
      capture(3'd4, 16'h0002);
      capture(3'd4, 16'h0003);
      settle_block();
      csr_access(1'b1, {REG_UNMAPPED, 2'b00}, 32'h0000_0000);
      csr_access(1'b0, {REG_UNMAPPED, 2'b00}, 32'd0);
      csr_access(1'b0, reg_addr(REG_COUNTER_PERIOD), 32'd0);
      csr_access(1'b0, reg_addr(REG_ENGINE_NUMERATOR), 32'd0);
   endtask

   // Run both timers for a long stretch of ticks, then capture on every channel
   task automatic test_overflow_runs;
      repeat (OVERFLOW_RUN_TICKS) overflow_tick(TIMER_WHEEL);
      repeat (OVERFLOW_RUN_TICKS) overflow_tick(TIMER_ENGINE);
      for (int ch = 0; ch < NCH; ch++) capture(3'(ch), 16'($urandom));
      overflow_tick(TIMER_WHEEL);
      capture(3'd0, 16'hFFFF);
      settle_block();
   endtask

   task automatic send_random_item(output int items);
      int pick;
      int burst;
      logic tmr;
      logic [2:0] ch;
      pick = $urandom_range(99);
      items = 1;
      if (pick < 40) begin
         overflow_tick(logic'($urandom_range(1)));
      end else if (pick < 45) begin
         tmr = logic'($urandom_range(1));
         burst = $urandom_range(40, 2);
         repeat (burst) overflow_tick(tmr);
         items = burst;
      end else if (pick < 92) begin
         ch = 3'($urandom_range(NCH - 1));
         capture(ch, ($urandom_range(4) == 0) ? gen_last[ch] : 16'($urandom));
      end else begin
         capture(3'($urandom_range(7, NCH)), 16'($urandom));
      end
   endtask

   // Random traffic over four idling mixes, new settings in each
   task automatic test_random_traffic;
      int send_mix [4];
      int recv_mix [4];
      int sent;
      int items;
      send_mix = '{0, 48, 0, 31};
      recv_mix = '{0, 0, 48, 31};
      for (int mix = 0; mix < 4; mix++) begin
         if (mix == 0) begin
            write_settings(COUNTER_PERIOD_RESET, WHEEL_NUMERATOR_RESET,
                           ENGINE_NUMERATOR_RESET);
         end else begin
            write_settings(16'($urandom_range(65535, 1)),
                           $urandom_range(32'hFFFF_FFFF, 1),
                           $urandom_range(32'hFFFF_FFFF, 1));
         end
         send_idle_pct = send_mix[mix];
         recv_stall_pct = recv_mix[mix];
         sent = 0;
         while (sent < RANDOM_ITEMS / 4) begin
            send_random_item(items);
            sent += items;
         end
         settle_block();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   // Hold the receiver off while captures keep coming, so the input backs up
   task automatic test_backpressure;
      holdoff_left = HOLDOFF_CYCLES;
      repeat (30) capture(3'($urandom_range(NCH - 1)), 16'($urandom));
      settle_block();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      holdoff_left = 0;
      quiet_cycles = 0;
      mismatch_count = 0;
      readings_checked = 0;
      zero_readings = 0;
      overflow_ticks = 0;
      settings_count = 0;
      for (int i = 0; i < NCH; i++) gen_last[i] = 16'h0000;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_values();
      test_basic_captures();
      test_ignored_channels();
      test_register_extremes();
      test_overflow_runs();
      test_random_traffic();
      test_backpressure();

      $display("covered %0d capture readings (%0d with zero period), %0d overflow ticks",
               readings_checked, zero_readings, overflow_ticks);
      $display("over %0d register settings, four idling mixes and a %0d-cycle hold-off",
               settings_count, HOLDOFF_CYCLES);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
